// ===== rtl/plint_pkg.sv =====
// Shared types, widths and constants of the Phong light intensity pipeline.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package plint_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;                    // field width
  localparam int LW         = DW + 1;                // light and eye vector parts
  localparam int RW         = 2 * DW + 2 - FRAC_BITS; // reflection vector parts
  localparam int SCALE_BITS = 30;                    // scaled parts stay below 2^30
  localparam int SW         = SCALE_BITS + 1;
  localparam int SHW        = $clog2(RW - SCALE_BITS + 1);
  localparam int CW         = FRAC_BITS + 2;         // cosine and power
  localparam int SQ_STEPS   = 32;                    // root digits of a 64-bit word
  localparam int SHIN_W     = 7;
  localparam int SHIN_MAX   = (1 << SHIN_W) - 1;
  localparam int QW         = 40;                    // dividend width of the /1000 unit
  localparam int DIV1000_LAT = 4;

  localparam int DIFF_GAIN = 65;
  localparam int SPEC_GAIN = 15;
  localparam logic [29:0] RECIP_1000 = 30'd549755813; // floor(2^39 / 1000)
  localparam logic [31:0] RECIP_100  = 32'd42949672;  // floor(2^32 / 100)
  localparam logic [SHIN_W-1:0] SHIN_RESET = SHIN_W'(50);
  localparam logic signed [QW-1:0] AMBIENT = QW'(40 * (1 << FRAC_BITS));

  typedef enum logic [2:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_EYE_X     = 3'd3,
    REG_EYE_Y     = 3'd4,
    REG_EYE_Z     = 3'd5,
    REG_SHININESS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [DW-1:0] normal_x;
    logic signed [DW-1:0] normal_y;
    logic signed [DW-1:0] normal_z;
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] intensity;
    logic                 degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [DW-1:0] light_x;
    logic signed [DW-1:0] light_y;
    logic signed [DW-1:0] light_z;
    logic signed [DW-1:0] eye_x;
    logic signed [DW-1:0] eye_y;
    logic signed [DW-1:0] eye_z;
    logic [SHIN_W-1:0]    shininess;
  } cfg_t;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t                 r;
    vec_t                 v;
    logic signed [DW-1:0] nol;
  } front_t;

  typedef struct packed {
    logic signed [63:0]   dot;
    logic [31:0]          len_r;
    logic [31:0]          len_v;
    logic signed [DW-1:0] nol;
    logic                 degen;
  } norm_t;

  typedef struct packed {
    logic signed [CW-1:0] cosv;
    logic signed [DW-1:0] nol;
    logic                 degen;
  } cos_t;

  typedef struct packed {
    logic signed [CW-1:0] p;
    logic signed [DW-1:0] nol;
    logic                 degen;
  } pow_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [66:0] x);
    if (x > 67'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -67'sd2147483648) begin
      return 32'sh80000000;
    end
    return DW'(x);
  endfunction

endpackage

// ===== rtl/phong_light_intensity.sv =====
// Phong light intensity: top level with the configuration registers and the
// stall control. Depends on plint_pkg and every plint_ module.
`timescale 1ns / 1ps

// One shaded point enters per clock while the pipeline is not held. The stages in order:
// the vector stages, the squares and the two pipelined square roots (one digit per
// stage), the cosine divider (one quotient bit per stage), the power chain (one
// multiplier per exponent step, the deepest part of the block) and the final scaling
// and output register. The whole pipeline holds as one while a result beat waits
// under out_stall, so in_stall follows that condition. The user must write the
// configuration only between items, with the pipeline empty; the block itself does
// not enforce it. There is no clearing pass after reset.

module phong_light_intensity
  import plint_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [DW-1:0]   cfg_data
);

  cfg_t   cfg_r;
  logic   en;
  logic   f_valid, n_valid, c_valid, p_valid;
  front_t f_data;
  norm_t  n_data;
  cos_t   c_data;
  pow_t   p_data;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_x   <= '0;
      cfg_r.light_y   <= '0;
      cfg_r.light_z   <= '0;
      cfg_r.eye_x     <= '0;
      cfg_r.eye_y     <= '0;
      cfg_r.eye_z     <= '0;
      cfg_r.shininess <= SHIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LIGHT_X:   cfg_r.light_x   <= cfg_data;
        REG_LIGHT_Y:   cfg_r.light_y   <= cfg_data;
        REG_LIGHT_Z:   cfg_r.light_z   <= cfg_data;
        REG_EYE_X:     cfg_r.eye_x     <= cfg_data;
        REG_EYE_Y:     cfg_r.eye_y     <= cfg_data;
        REG_EYE_Z:     cfg_r.eye_z     <= cfg_data;
        REG_SHININESS: cfg_r.shininess <= cfg_data[SHIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  plint_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  plint_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (n_valid),
    .out_data  (n_data)
  );

  plint_cosine u_cosine (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n_valid),
    .in_data   (n_data),
    .out_valid (c_valid),
    .out_data  (c_data)
  );

  plint_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .shininess (cfg_r.shininess),
    .in_valid  (c_valid),
    .in_data   (c_data),
    .out_valid (p_valid),
    .out_data  (p_data)
  );

  plint_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .in_data   (p_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/plint_div100.sv =====
// Two lanes of truncating division by 100, by reciprocal multiply and one correction.
// Three register stages. Depends on plint_pkg.
`timescale 1ns / 1ps

module plint_div100
  import plint_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] x [2],
  output logic signed [DW-1:0] q [2]
);

  logic [31:0] u1_r [2];
  logic        n1_r [2];
  logic [31:0] u2_r [2];
  logic        n2_r [2];
  logic [31:0] q2_r [2];
  logic [31:0] u3_r [2];
  logic        n3_r [2];
  logic [31:0] q3_r [2];
  logic [31:0] k3_r [2];

  always_ff @(posedge clk) begin
    logic signed [32:0] xe;
    logic [63:0]        prod;
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        xe      = 33'(x[i]);
        n1_r[i] <= x[i] < 0;
        u1_r[i] <= (x[i] < 0) ? 32'(-xe) : 32'(xe);
        prod    = 64'(u1_r[i]) * 64'(RECIP_100);
        q2_r[i] <= prod[63:32];
        u2_r[i] <= u1_r[i];
        n2_r[i] <= n1_r[i];
        k3_r[i] <= q2_r[i] * 32'd100;
        q3_r[i] <= q2_r[i];
        u3_r[i] <= u2_r[i];
        n3_r[i] <= n2_r[i];
      end
    end
  end

  // The estimate is low by at most one.
  always_comb begin
    logic [31:0] rem;
    logic [31:0] qq;
    for (int i = 0; i < 2; i++) begin
      rem  = u3_r[i] - k3_r[i];
      qq   = (rem >= 32'd100) ? q3_r[i] + 32'd1 : q3_r[i];
      q[i] = n3_r[i] ? DW'(-qq) : DW'(qq);
    end
  end

endmodule

// ===== rtl/plint_div1000.sv =====
// Floor division of a signed value by 1000: reciprocal multiply in two partial
// products, then one correction. Four register stages. Depends on plint_pkg.
`timescale 1ns / 1ps

module plint_div1000
  import plint_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [QW-1:0] x,
  output logic signed [DW-1:0] q
);

  logic [QW-2:0] u1_r, u2_r, u3_r, u4_r;
  logic          n1_r, n2_r, n3_r, n4_r;
  logic [48:0]   hm_r;
  logic [49:0]   lm_r;
  logic [29:0]   q3_r, q4_r;
  logic [QW-1:0] k4_r;

  always_ff @(posedge clk) begin
    logic [69:0] sum;
    if (en) begin
      // For a negative x, floor(x/1000) is the complement of floor(~x/1000).
      n1_r <= x[QW-1];
      u1_r <= x[QW-1] ? (QW-1)'(~x) : (QW-1)'(x);
      hm_r <= 49'(u1_r[QW-2:20]) * 49'(RECIP_1000);
      lm_r <= 50'(u1_r[19:0]) * 50'(RECIP_1000);
      u2_r <= u1_r;
      n2_r <= n1_r;
      sum  = (70'(hm_r) << 20) + 70'(lm_r);
      q3_r <= sum[68:39];
      u3_r <= u2_r;
      n3_r <= n2_r;
      k4_r <= QW'(q3_r) * QW'(1000);
      q4_r <= q3_r;
      u4_r <= u3_r;
      n4_r <= n3_r;
    end
  end

  always_comb begin
    logic [QW-1:0] rem;
    logic [DW-1:0] qq;
    rem = QW'(u4_r) - k4_r;
    qq  = (rem >= QW'(1000)) ? DW'(q4_r) + DW'(1) : DW'(q4_r);
    q   = n4_r ? ~qq : qq;
  end

endmodule

// ===== rtl/plint_front.sv =====
// Vector stages: light and eye vectors, N.L, the reflection vector and the
// block scaling of R and V. Eleven register stages. Depends on plint_pkg, plint_div100.
`timescale 1ns / 1ps

module plint_front
  import plint_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     out_valid,
  output front_t   out_data
);

  localparam int DLY = 3;
  localparam int NST = DLY + 8;

  typedef struct packed {
    logic signed [DW-1:0] nx, ny, nz;
    logic signed [LW-1:0] lx, ly, vx, vy, vz;
  } pre_t;

  typedef struct packed {
    logic signed [DW-1:0] nx, ny, nz;
    logic signed [LW-1:0] lx, ly, lz, vx, vy, vz;
  } nlv_t;

  typedef struct packed {
    logic signed [LW-1:0] lx, ly, lz, vx, vy, vz;
  } lv_t;

  typedef struct packed {
    logic signed [RW-1:0] rx, ry, rz;
    logic signed [LW-1:0] vx, vy, vz;
  } rv_t;

  function automatic logic [RW-1:0] mag(input logic signed [RW-1:0] a);
    return (a < 0) ? RW'(-a) : RW'(a);
  endfunction

  // Smallest right shift that brings every part below 2^SCALE_BITS.
  function automatic logic [SHW-1:0] shift_of(input logic [RW-1:0] m);
    logic [SHW-1:0] s;
    s = '0;
    for (int j = 0; j < RW - SCALE_BITS; j++) begin
      if ((m >> (SCALE_BITS + j)) != '0) begin
        s = SHW'(j + 1);
      end
    end
    return s;
  endfunction

  pre_t                 pre_nxt;
  pre_t                 pre_r [DLY];
  logic signed [DW-1:0] dz_x [2];
  logic signed [DW-1:0] dz_q [2];
  nlv_t                 b_nxt, b_r, c_r, d_r;
  logic signed [DW+LW-1:0] c_px_r, c_py_r, c_pz_r;
  logic signed [DW-1:0] d_nol_r, e_nol_r, f_nol_r, g_nol_r, h_nol_r;
  logic signed [2*DW-1:0] e_nx_r, e_ny_r, e_nz_r;
  lv_t                  e_lv_r;
  rv_t                  f_rv_r, g_rv_r, h_rv_r;
  logic [RW-1:0]        g_orr_r, g_orv_r;
  logic [SHW-1:0]       h_sr_r, h_sv_r;
  front_t               i_r;
  logic [NST-1:0]       vld_r;

  always_comb begin
    pre_nxt.nx = in_item.normal_x;
    pre_nxt.ny = in_item.normal_y;
    pre_nxt.nz = in_item.normal_z;
    pre_nxt.lx = LW'(cfg.light_x) - LW'(in_item.pos_x);
    pre_nxt.ly = LW'(cfg.light_y) - LW'(in_item.pos_y);
    pre_nxt.vx = LW'(cfg.eye_x) - LW'(in_item.pos_x);
    pre_nxt.vy = LW'(cfg.eye_y) - LW'(in_item.pos_y);
    pre_nxt.vz = LW'(cfg.eye_z) - LW'(in_item.pos_z);
  end

  // Both z parts are divided by 100 on their own before they are subtracted.
  assign dz_x[0] = cfg.light_z;
  assign dz_x[1] = in_item.pos_z;

  plint_div100 u_div100 (
    .clk (clk),
    .en  (en),
    .x   (dz_x),
    .q   (dz_q)
  );

  always_comb begin
    b_nxt.nx = pre_r[DLY-1].nx;
    b_nxt.ny = pre_r[DLY-1].ny;
    b_nxt.nz = pre_r[DLY-1].nz;
    b_nxt.lx = pre_r[DLY-1].lx;
    b_nxt.ly = pre_r[DLY-1].ly;
    b_nxt.lz = LW'(dz_q[0]) - LW'(dz_q[1]);
    b_nxt.vx = pre_r[DLY-1].vx;
    b_nxt.vy = pre_r[DLY-1].vy;
    b_nxt.vz = pre_r[DLY-1].vz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r[0] <= pre_nxt;
      for (int k = 1; k < DLY; k++) begin
        pre_r[k] <= pre_r[k-1];
      end
      b_r <= b_nxt;

      c_px_r <= (DW+LW)'(b_r.nx) * (DW+LW)'(b_r.lx);
      c_py_r <= (DW+LW)'(b_r.ny) * (DW+LW)'(b_r.ly);
      c_pz_r <= (DW+LW)'(b_r.nz) * (DW+LW)'(b_r.lz);
      c_r    <= b_r;

      d_nol_r <= sat32((67'(c_px_r) >>> FRAC_BITS) + (67'(c_py_r) >>> FRAC_BITS)
                       + (67'(c_pz_r) >>> FRAC_BITS));
      d_r     <= c_r;

      e_nx_r    <= (2*DW)'(d_nol_r) * (2*DW)'(d_r.nx);
      e_ny_r    <= (2*DW)'(d_nol_r) * (2*DW)'(d_r.ny);
      e_nz_r    <= (2*DW)'(d_nol_r) * (2*DW)'(d_r.nz);
      e_nol_r   <= d_nol_r;
      e_lv_r.lx <= d_r.lx;
      e_lv_r.ly <= d_r.ly;
      e_lv_r.lz <= d_r.lz;
      e_lv_r.vx <= d_r.vx;
      e_lv_r.vy <= d_r.vy;
      e_lv_r.vz <= d_r.vz;

      f_rv_r.rx <= RW'(e_lv_r.lx) - (RW'(e_nx_r >>> FRAC_BITS) <<< 1);
      f_rv_r.ry <= RW'(e_lv_r.ly) - (RW'(e_ny_r >>> FRAC_BITS) <<< 1);
      f_rv_r.rz <= RW'(e_lv_r.lz) - (RW'(e_nz_r >>> FRAC_BITS) <<< 1);
      f_rv_r.vx <= e_lv_r.vx;
      f_rv_r.vy <= e_lv_r.vy;
      f_rv_r.vz <= e_lv_r.vz;
      f_nol_r   <= e_nol_r;

      // The OR of the magnitudes has the bit length of the largest one.
      g_orr_r <= mag(f_rv_r.rx) | mag(f_rv_r.ry) | mag(f_rv_r.rz);
      g_orv_r <= mag(RW'(f_rv_r.vx)) | mag(RW'(f_rv_r.vy)) | mag(RW'(f_rv_r.vz));
      g_rv_r  <= f_rv_r;
      g_nol_r <= f_nol_r;

      h_sr_r  <= shift_of(g_orr_r);
      h_sv_r  <= shift_of(g_orv_r);
      h_rv_r  <= g_rv_r;
      h_nol_r <= g_nol_r;

      i_r.r.x <= SW'(h_rv_r.rx >>> h_sr_r);
      i_r.r.y <= SW'(h_rv_r.ry >>> h_sr_r);
      i_r.r.z <= SW'(h_rv_r.rz >>> h_sr_r);
      i_r.v.x <= SW'(h_rv_r.vx >>> h_sv_r);
      i_r.v.y <= SW'(h_rv_r.vy >>> h_sv_r);
      i_r.v.z <= SW'(h_rv_r.vz >>> h_sv_r);
      i_r.nol <= h_nol_r;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = i_r;

endmodule

// ===== rtl/plint_sqrt.sv =====
// Pipelined floor square root of a 64-bit word, one result digit per stage.
// Depends on plint_pkg.
`timescale 1ns / 1ps

module plint_sqrt
  import plint_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);

  logic [63:0] rem_r [SQ_STEPS];
  logic [63:0] res_r [SQ_STEPS];
  logic [63:0] rem_nxt [SQ_STEPS];
  logic [63:0] res_nxt [SQ_STEPS];

  always_comb begin
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    logic [63:0] t;
    for (int j = 0; j < SQ_STEPS; j++) begin
      rem   = (j == 0) ? n : rem_r[(j == 0) ? 0 : j - 1];
      res   = (j == 0) ? 64'd0 : res_r[(j == 0) ? 0 : j - 1];
      bit_w = 64'd1 << (62 - 2 * j);
      t     = res + bit_w;
      if (rem >= t) begin
        rem_nxt[j] = rem - t;
        res_nxt[j] = (res >> 1) + bit_w;
      end else begin
        rem_nxt[j] = rem;
        res_nxt[j] = res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign root = res_r[SQ_STEPS-1][31:0];

endmodule

// ===== rtl/plint_norm.sv =====
// Squares, dot product and the two vector lengths of the scaled R and V.
// 2 + SQ_STEPS register stages. Depends on plint_pkg, plint_sqrt.
`timescale 1ns / 1ps

module plint_norm
  import plint_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  front_t in_data,
  output logic   out_valid,
  output norm_t  out_data
);

  localparam int NST = 2 + SQ_STEPS;

  typedef struct packed {
    logic signed [63:0]   dot;
    logic signed [DW-1:0] nol;
    logic                 degen;
  } side_t;

  logic signed [SW-1:0]   rc [3];
  logic signed [SW-1:0]   vc [3];
  logic signed [2*SW-1:0] rr_p_r [3];
  logic signed [2*SW-1:0] vv_p_r [3];
  logic signed [2*SW-1:0] rv_p_r [3];
  logic signed [DW-1:0]   nol1_r, nol2_r;
  logic [63:0]            rr_r, vv_r;
  logic signed [63:0]     dot_r;
  side_t                  side_r [SQ_STEPS];
  logic [31:0]            len_r, len_v;
  logic [NST-1:0]         vld_r;

  assign rc[0] = in_data.r.x;
  assign rc[1] = in_data.r.y;
  assign rc[2] = in_data.r.z;
  assign vc[0] = in_data.v.x;
  assign vc[1] = in_data.v.y;
  assign vc[2] = in_data.v.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rr_p_r[i] <= (2*SW)'(rc[i]) * (2*SW)'(rc[i]);
        vv_p_r[i] <= (2*SW)'(vc[i]) * (2*SW)'(vc[i]);
        rv_p_r[i] <= (2*SW)'(rc[i]) * (2*SW)'(vc[i]);
      end
      nol1_r <= in_data.nol;

      rr_r   <= 64'(rr_p_r[0]) + 64'(rr_p_r[1]) + 64'(rr_p_r[2]);
      vv_r   <= 64'(vv_p_r[0]) + 64'(vv_p_r[1]) + 64'(vv_p_r[2]);
      dot_r  <= 64'(rv_p_r[0]) + 64'(rv_p_r[1]) + 64'(rv_p_r[2]);
      nol2_r <= nol1_r;

      side_r[0].dot   <= dot_r;
      side_r[0].nol   <= nol2_r;
      side_r[0].degen <= (rr_r == '0) || (vv_r == '0);
      for (int k = 1; k < SQ_STEPS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  plint_sqrt u_sqrt_r (
    .clk  (clk),
    .en   (en),
    .n    (rr_r),
    .root (len_r)
  );

  plint_sqrt u_sqrt_v (
    .clk  (clk),
    .en   (en),
    .n    (vv_r),
    .root (len_v)
  );

  assign out_valid      = vld_r[NST-1];
  assign out_data.dot   = side_r[SQ_STEPS-1].dot;
  assign out_data.len_r = len_r;
  assign out_data.len_v = len_v;
  assign out_data.nol   = side_r[SQ_STEPS-1].nol;
  assign out_data.degen = side_r[SQ_STEPS-1].degen;

endmodule

// ===== rtl/plint_cosine.sv =====
// Cosine of the angle between R and V: |R.V| / (|R||V|) by restoring division,
// one quotient bit per stage, limited to 1.0 and signed. Depends on plint_pkg.
`timescale 1ns / 1ps

module plint_cosine
  import plint_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  norm_t in_data,
  output logic  out_valid,
  output cos_t  out_data
);

  localparam int NST = FRAC_BITS + 2;

  typedef struct packed {
    logic [63:0]          rem;
    logic [63:0]          den;
    logic [FRAC_BITS-1:0] q;
    logic                 sat;
    logic                 neg;
    logic signed [DW-1:0] nol;
    logic                 degen;
  } dv_t;

  function automatic dv_t div_step(input dv_t s);
    dv_t         t;
    logic [63:0] sh;
    t  = s;
    sh = s.rem << 1;
    if (sh >= s.den) begin
      t.rem = sh - s.den;
      t.q   = {s.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      t.rem = sh;
      t.q   = {s.q[FRAC_BITS-2:0], 1'b0};
    end
    return t;
  endfunction

  dv_t            a_nxt, a_r, first;
  dv_t            dv_r [FRAC_BITS];
  cos_t           c_r;
  logic [NST-1:0] vld_r;

  always_comb begin
    a_nxt.den   = 64'(in_data.len_r) * 64'(in_data.len_v);
    a_nxt.rem   = (in_data.dot < 0) ? 64'(-in_data.dot) : 64'(in_data.dot);
    a_nxt.q     = '0;
    a_nxt.sat   = 1'b0;
    a_nxt.neg   = in_data.dot < 0;
    a_nxt.nol   = in_data.nol;
    a_nxt.degen = in_data.degen;
    first       = a_r;
    first.sat   = a_r.rem >= a_r.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] c;
    if (en) begin
      a_r     <= a_nxt;
      dv_r[0] <= div_step(first);
      for (int k = 1; k < FRAC_BITS; k++) begin
        dv_r[k] <= div_step(dv_r[k-1]);
      end
      c = dv_r[FRAC_BITS-1].sat ? CW'(1 << FRAC_BITS) : CW'(dv_r[FRAC_BITS-1].q);
      c_r.cosv  <= dv_r[FRAC_BITS-1].neg ? -c : c;
      c_r.nol   <= dv_r[FRAC_BITS-1].nol;
      c_r.degen <= dv_r[FRAC_BITS-1].degen;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = c_r;

endmodule

// ===== rtl/plint_power.sv =====
// Cosine raised to the shininess exponent: one multiply and floor shift per
// stage, SHIN_MAX stages; stages past the exponent pass the value on.
// Depends on plint_pkg.
`timescale 1ns / 1ps

module plint_power
  import plint_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [SHIN_W-1:0] shininess,
  input  logic              in_valid,
  input  cos_t              in_data,
  output logic              out_valid,
  output pow_t              out_data
);

  typedef struct packed {
    logic signed [CW-1:0] p;
    logic signed [CW-1:0] c;
    logic signed [DW-1:0] nol;
    logic                 degen;
  } pst_t;

  pst_t                pst_r [SHIN_MAX];
  pst_t                pst_nxt [SHIN_MAX];
  logic [SHIN_MAX-1:0] vld_r;

  always_comb begin
    pst_t                   prev;
    logic signed [2*CW-1:0] prod;
    for (int k = 0; k < SHIN_MAX; k++) begin
      if (k == 0) begin
        prev.p     = CW'(1 << FRAC_BITS);
        prev.c     = in_data.cosv;
        prev.nol   = in_data.nol;
        prev.degen = in_data.degen;
      end else begin
        prev = pst_r[(k == 0) ? 0 : k - 1];
      end
      prod       = (2*CW)'(prev.p) * (2*CW)'(prev.c);
      pst_nxt[k] = prev;
      if (SHIN_W'(k) < shininess) begin
        pst_nxt[k].p = CW'(prod >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SHIN_MAX-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pst_r <= pst_nxt;
    end
  end

  assign out_valid      = vld_r[SHIN_MAX-1];
  assign out_data.p     = pst_r[SHIN_MAX-1].p;
  assign out_data.nol   = pst_r[SHIN_MAX-1].nol;
  assign out_data.degen = pst_r[SHIN_MAX-1].degen;

endmodule

// ===== rtl/plint_tail.sv =====
// Diffuse and specular scaling by 65/1000 and 15/1000, the ambient term, the
// negation with saturation and the output register. Depends on plint_pkg, plint_div1000.
`timescale 1ns / 1ps

module plint_tail
  import plint_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  pow_t      in_data,
  output logic      out_valid,
  output out_item_t out_item
);

  logic signed [QW-1:0] x_spec, x_diff;
  logic signed [DW-1:0] q_spec, q_diff;
  logic [DIV1000_LAT-1:0] vld_r;
  logic [DIV1000_LAT-1:0] deg_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  assign x_spec = QW'(in_data.p) * QW'(SPEC_GAIN);
  assign x_diff = QW'(in_data.nol) * QW'(DIFF_GAIN);

  plint_div1000 u_div_spec (
    .clk (clk),
    .en  (en),
    .x   (x_spec),
    .q   (q_spec)
  );

  plint_div1000 u_div_diff (
    .clk (clk),
    .en  (en),
    .x   (x_diff),
    .q   (q_diff)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DIV1000_LAT-2:0], in_valid};
      out_valid_r <= vld_r[DIV1000_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [QW-1:0] spec;
    logic signed [QW-1:0] total;
    if (en) begin
      deg_r <= {deg_r[DIV1000_LAT-2:0], in_data.degen};
      // A zero-length R or V drops the specular term.
      spec  = deg_r[DIV1000_LAT-1] ? QW'(0) : QW'(q_spec);
      total = AMBIENT + QW'(q_diff) + spec;
      out_item_r.intensity  <= sat32(67'(-total));
      out_item_r.degenerate <= deg_r[DIV1000_LAT-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for phong_light_intensity: a scoreboard class predicts
// the intensity and the degenerate flag of each point; tasks drive the block.
// Depends on plint_pkg and the RTL of the block.
`timescale 1ns / 1ps

class light_scoreboard;
  logic signed [31:0] light_x, light_y, light_z, eye_x, eye_y, eye_z;
  logic [6:0]         shininess;
  plint_pkg::out_item_t expected_q[$];
  int                 mismatches;

  function new();
    reset_regs();
    mismatches = 0;
  endfunction

  function void reset_regs();
    light_x = 0; light_y = 0; light_z = 0;
    eye_x = 0; eye_y = 0; eye_z = 0;
    shininess = 7'd50;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (plint_pkg::reg_idx_t'(idx))
      plint_pkg::REG_LIGHT_X:   light_x = data;
      plint_pkg::REG_LIGHT_Y:   light_y = data;
      plint_pkg::REG_LIGHT_Z:   light_z = data;
      plint_pkg::REG_EYE_X:     eye_x = data;
      plint_pkg::REG_EYE_Y:     eye_y = data;
      plint_pkg::REG_EYE_Z:     eye_z = data;
      plint_pkg::REG_SHININESS: shininess = data[6:0];
      default: ;
    endcase
  endfunction

  static function longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  static function longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  static function longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  static function longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Shift all three parts right by the smallest common amount that brings
  // each below 2^30 in magnitude.
  static function void scale_down(inout longint vec [3]);
    longint unsigned m;
    int s;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) if (magnitude(vec[i]) > m) m = magnitude(vec[i]);
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) vec[i] = vec[i] >>> s;
  endfunction

  function plint_pkg::out_item_t shade(plint_pkg::in_item_t it);
    longint n [3], l [3], r [3], v [3];
    longint nol, spec, total, dot, c, p;
    longint unsigned rr, vv, den, a, q, rem;
    plint_pkg::out_item_t res;
    n[0] = it.normal_x; n[1] = it.normal_y; n[2] = it.normal_z;
    l[0] = longint'(light_x) - longint'(it.pos_x);
    l[1] = longint'(light_y) - longint'(it.pos_y);
    l[2] = longint'(light_z) / 100 - longint'(it.pos_z) / 100;
    v[0] = longint'(eye_x) - longint'(it.pos_x);
    v[1] = longint'(eye_y) - longint'(it.pos_y);
    v[2] = longint'(eye_z) - longint'(it.pos_z);
    nol = 0;
    for (int i = 0; i < 3; i++) nol += (n[i] * l[i]) >>> 16;
    nol = clamp32(nol);
    for (int i = 0; i < 3; i++) r[i] = l[i] - 2 * ((nol * n[i]) >>> 16);
    scale_down(r);
    scale_down(v);
    rr = 0; vv = 0; dot = 0; spec = 0;
    for (int i = 0; i < 3; i++) begin
      rr += r[i] * r[i];
      vv += v[i] * v[i];
      dot += r[i] * v[i];
    end
    res.degenerate = (rr == 0 || vv == 0);
    if (!res.degenerate) begin
      den = root_floor(rr) * root_floor(vv);
      a = magnitude(dot);
      if (a >= den) begin
        c = 64'sd1 << 16;
      end else begin
        q = 0;
        rem = a;
        for (int i = 0; i < 16; i++) begin
          rem <<= 1;
          q <<= 1;
          if (rem >= den) begin
            rem -= den;
            q |= 1;
          end
        end
        c = q;
      end
      if (dot < 0) c = -c;
      p = 64'sd1 << 16;
      for (int k = 0; k < shininess; k++) p = (p * c) >>> 16;
      spec = floor_div(p * 15, 1000);
    end
    total = (64'sd40 << 16) + floor_div(nol * 65, 1000) + spec;
    res.intensity = 32'(clamp32(-total));
    return res;
  endfunction

  function void note_point(plint_pkg::in_item_t it);
    expected_q.insert(expected_q.size(), shade(it));
  endfunction

  function void check_result(plint_pkg::out_item_t got);
    plint_pkg::out_item_t exp_item;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_item = expected_q.pop_front();
    if (got.intensity !== exp_item.intensity || got.degenerate !== exp_item.degenerate) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: intensity exp %h got %h, degenerate exp %b got %b",
                 exp_item.intensity, got.intensity, exp_item.degenerate, got.degenerate);
    end
  endfunction
endclass

module testbench;
  import plint_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  light_scoreboard shade_sb = new();
  idle_mode_t      idle_mode = IDLE_NONE;
  longint          cycles = 0;

  phong_light_intensity u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: stall chosen at the falling edge, results taken at the rising edge.
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall = $urandom_range(99) < 65;
      IDLE_BOTH:     out_stall = $urandom_range(99) < 11;
      default:       out_stall = 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shade_sb.check_result(out_item);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    shade_sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_point(in_item_t it);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 65 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    shade_sb.note_point(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (shade_sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] near_value(int unsigned span);
    return 32'($signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly scene-like points (unit-ish normals, x and y positions within 200 units,
  // z within 20000), with some full-range and range-edge fields mixed in.
  function automatic in_item_t random_point();
    in_item_t it;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      it.normal_x = near_value(32'h0001_0000);
      it.normal_y = near_value(32'h0001_0000);
      it.normal_z = near_value(32'h0001_0000);
      it.pos_x = near_value(32'h00c8_0000);
      it.pos_y = near_value(32'h00c8_0000);
      it.pos_z = near_value(32'h4e20_0000);
    end else if (kind < 90) begin
      it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      it = {edge_value(), edge_value(), edge_value(), edge_value(), edge_value(),
            edge_value()};
    end
    return it;
  endfunction

  task automatic random_config(int unsigned pick);
    write_reg(REG_LIGHT_X, pick == 0 ? $urandom() : near_value(32'h0100_0000));
    write_reg(REG_LIGHT_Y, pick == 0 ? $urandom() : near_value(32'h0100_0000));
    write_reg(REG_LIGHT_Z, pick == 0 ? $urandom() : near_value(32'h7000_0000));
    write_reg(REG_EYE_X, pick == 0 ? $urandom() : near_value(32'h0100_0000));
    write_reg(REG_EYE_Y, pick == 0 ? $urandom() : near_value(32'h0100_0000));
    write_reg(REG_EYE_Z, pick == 0 ? $urandom() : near_value(32'h0100_0000));
    write_reg(REG_SHININESS, $urandom_range(1, 127));
  endtask

  initial begin
    in_item_t it;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed points under the reset settings: everything at the origin makes
    // both the reflection and the eye vector zero.
    send_point('0);
    send_point({32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
    send_point({6{32'h8000_0000}});
    send_point({6{32'h7fff_ffff}});
    send_point({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000});
    send_point({32'hffff_ffff, 32'h0000_0001, 32'hffff_0000, 32'h0, 32'h0, 32'h0063_0000});
    drain();

    write_reg(REG_LIGHT_X, 32'h000a_0000);
    write_reg(REG_LIGHT_Y, 32'h0014_0000);
    write_reg(REG_LIGHT_Z, 32'h012c_0000);
    write_reg(REG_EYE_X, 32'h0);
    write_reg(REG_EYE_Y, 32'h0);
    write_reg(REG_EYE_Z, 32'h0032_0000);
    write_reg(REG_SHININESS, 32'd127);
    write_reg(REG_UNUSED, 32'hdead_beef);
    // Point at the camera: the eye vector is zero.
    send_point({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0032_0000});
    // Point at the light with a zero normal: the reflection is zero.
    send_point({32'h0, 32'h0, 32'h0, 32'h000a_0000, 32'h0014_0000, 32'h012c_0000});
    send_point({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0});
    send_point({32'h0, 32'h0, 32'hffff_0000, 32'h0, 32'h0, 32'h0});
    send_point({32'h0000_b505, 32'h0000_b505, 32'h0, 32'h0005_0000, 32'h0, 32'h0});
    drain();
    write_reg(REG_SHININESS, 32'd1);
    send_point({32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    send_point({32'h0, 32'hffff_0000, 32'h0, 32'h0003_0000, 32'hfffe_0000, 32'h0});
    drain();
    write_reg(REG_SHININESS, 32'd0);
    send_point({32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = idle_mode_t'(ph % 4);
      random_config(ph == 5 ? 0 : 1);
      if (ph == 7) begin
        write_reg(REG_LIGHT_Z, 32'h7fff_ffff);
        write_reg(REG_EYE_X, 32'h8000_0000);
      end
      for (int k = 0; k < 210; k++) begin
        it = random_point();
        send_point(it);
        if (ph == 2 && k == 100) drain();
      end
      drain();
    end

    repeat (250) @(posedge clk);
    if (shade_sb.mismatches == 0 && shade_sb.expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
